// ===== rtl/hbd_pkg.sv =====
// types and constants shared by the http body deframer
`timescale 1ns / 1ps

package hbd_pkg;

  // widths of the word fields
  localparam int unsigned LenW  = 31;
  localparam int unsigned ByteW = 8;
  localparam int unsigned StatW = 3;

  // default limit on hex digits in one chunk size line
  localparam int unsigned MAX_SIZE_DIGITS = 8;

  // reset value of the body size limit
  localparam logic [LenW-1:0] MAX_BODY_RESET = 31'd1048576;

  // status codes
  localparam logic [StatW-1:0] ST_RUN    = 3'd0;
  localparam logic [StatW-1:0] ST_DONE   = 3'd1;
  localparam logic [StatW-1:0] ST_BAD    = 3'd2;
  localparam logic [StatW-1:0] ST_LARGE  = 3'd3;
  localparam logic [StatW-1:0] ST_LENREQ = 3'd4;

  // input word: start of a body or one body byte
  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data_in;
    logic             chunked;
    logic             length_known;
    logic [LenW-1:0]  content_length;
    logic             bytes_follow;
    logic             has_trailers;
    logic             skip_body;
  } in_t;

  // result word
  typedef struct packed {
    logic             data_valid;
    logic [ByteW-1:0] data_out;
    logic [StatW-1:0] status;
    logic [LenW-1:0]  body_bytes;
  } out_t;

endpackage

// ===== rtl/http_body_deframer.sv =====
// http body deframer: length and chunked body framing, one byte per word
// result: a registered result word appears in the cycle after its input word is accepted
// throughput: one input word per cycle; the output register stalls the input
//   only while a held result word is itself stalled
// reset: framing state idle, counters zero, size limit back to 1048576,
//   output register empty
`timescale 1ns / 1ps

module http_body_deframer #(
  parameter int unsigned MaxSizeDigits = hbd_pkg::MAX_SIZE_DIGITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  hbd_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output hbd_pkg::out_t            out_data_o,
  input  logic                     cfg_we_i,
  input  logic [hbd_pkg::LenW-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MaxSizeDigits + 1);
  localparam int unsigned LenW = hbd_pkg::LenW;

  // phase codes
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_LEN      = 4'd1;
  localparam logic [3:0] PH_LINE     = 4'd2;
  localparam logic [3:0] PH_SKIP_LF  = 4'd3;
  localparam logic [3:0] PH_SIZE     = 4'd4;
  localparam logic [3:0] PH_SIZE_LF  = 4'd5;
  localparam logic [3:0] PH_DATA     = 4'd6;
  localparam logic [3:0] PH_DATA_CR  = 4'd7;
  localparam logic [3:0] PH_DATA_LF  = 4'd8;
  localparam logic [3:0] PH_END_CR   = 4'd9;
  localparam logic [3:0] PH_END_LF   = 4'd10;
  localparam logic [3:0] PH_FINISHED = 4'd11;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  // hex digit decode: bit 4 flags a valid digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  logic [LenW-1:0]          max_body_q;
  logic [3:0]               phase_q, phase_d;
  logic [LenW-1:0]          remaining_q, remaining_d;
  logic [31:0]              size_accum_q, size_accum_d;
  logic [CntW-1:0]          digit_count_q, digit_count_d;
  logic [LenW-1:0]          accepted_q, accepted_d;
  logic                     over_limit_q, over_limit_d;
  logic [hbd_pkg::StatW-1:0] final_status_q, final_status_d;
  logic                     out_valid_q;
  hbd_pkg::out_t            out_q, out_d;

  logic                     in_accept;
  logic                     out_free;
  logic                     pass;
  logic [7:0]               c;
  logic [4:0]               hex;
  logic [LenW-1:0]          rem_dec;
  logic [LenW-1:0]          acc_inc;
  logic [LenW+1:0]          limit_sum;
  logic                     digit_full;
  logic [31:0]              accum_shift;

  // handshake: the output register frees its slot when empty or taken
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !out_free;
  assign in_accept   = in_valid_i && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // datapath helpers
  assign c           = in_data_i.data_in;
  assign hex         = hex_decode(c);
  assign rem_dec     = remaining_q - 1'b1;
  assign acc_inc     = accepted_q + 1'b1;
  assign limit_sum   = {2'b0, accepted_q} + {1'b0, size_accum_q};
  assign digit_full  = digit_count_q >= CntW'(MaxSizeDigits);
  assign accum_shift = (size_accum_q > 32'h0fff_ffff) ? 32'hffff_ffff
                                                      : {size_accum_q[27:0], hex[3:0]};

  // next framing state for one word
  always_comb begin
    phase_d        = phase_q;
    remaining_d    = remaining_q;
    size_accum_d   = size_accum_q;
    digit_count_d  = digit_count_q;
    accepted_d     = accepted_q;
    over_limit_d   = over_limit_q;
    final_status_d = final_status_q;
    pass           = 1'b0;

    if (!in_data_i.kind) begin
      // start of a body
      remaining_d    = '0;
      size_accum_d   = '0;
      digit_count_d  = '0;
      accepted_d     = '0;
      over_limit_d   = 1'b0;
      final_status_d = hbd_pkg::ST_RUN;
      if (in_data_i.skip_body) begin
        phase_d        = PH_FINISHED;
        final_status_d = hbd_pkg::ST_DONE;
      end else if (in_data_i.chunked) begin
        phase_d = PH_LINE;
      end else if (in_data_i.length_known) begin
        over_limit_d = in_data_i.content_length > max_body_q;
        remaining_d  = in_data_i.content_length;
        phase_d      = PH_LEN;
        if (in_data_i.content_length == '0) begin
          phase_d        = PH_FINISHED;
          final_status_d = (in_data_i.content_length > max_body_q) ? hbd_pkg::ST_LARGE
                                                                   : hbd_pkg::ST_DONE;
        end
      end else begin
        phase_d        = PH_FINISHED;
        final_status_d = (in_data_i.bytes_follow && !in_data_i.has_trailers)
                         ? hbd_pkg::ST_LENREQ : hbd_pkg::ST_DONE;
      end
    end else begin
      // one body byte
      case (phase_q)
        PH_LEN: begin
          if (!over_limit_q) begin
            pass       = 1'b1;
            accepted_d = acc_inc;
          end
          remaining_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d        = PH_FINISHED;
            final_status_d = over_limit_q ? hbd_pkg::ST_LARGE : hbd_pkg::ST_DONE;
          end
        end
        PH_LINE: begin
          if (c == CHAR_CR) begin
            phase_d = PH_SKIP_LF;
          end else if (!hex[4]) begin
            phase_d        = PH_FINISHED;
            final_status_d = hbd_pkg::ST_BAD;
          end else begin
            size_accum_d  = {28'd0, hex[3:0]};
            digit_count_d = CntW'(1);
            phase_d       = PH_SIZE;
          end
        end
        PH_SKIP_LF: begin
          if (c == CHAR_LF) begin
            phase_d = PH_LINE;
          end else begin
            phase_d        = PH_FINISHED;
            final_status_d = hbd_pkg::ST_BAD;
          end
        end
        PH_SIZE: begin
          if (c == CHAR_CR) begin
            phase_d = PH_SIZE_LF;
          end else if (!hex[4] || digit_full) begin
            phase_d        = PH_FINISHED;
            final_status_d = hbd_pkg::ST_BAD;
          end else begin
            digit_count_d = digit_count_q + 1'b1;
            size_accum_d  = accum_shift;
          end
        end
        PH_SIZE_LF: begin
          if (c != CHAR_LF) begin
            phase_d        = PH_FINISHED;
            final_status_d = hbd_pkg::ST_BAD;
          end else if (limit_sum > {2'b0, max_body_q}) begin
            phase_d        = PH_FINISHED;
            final_status_d = hbd_pkg::ST_LARGE;
          end else if (size_accum_q == '0) begin
            phase_d = PH_END_CR;
          end else begin
            remaining_d = size_accum_q[LenW-1:0];
            phase_d     = PH_DATA;
          end
        end
        PH_DATA: begin
          pass        = 1'b1;
          accepted_d  = acc_inc;
          remaining_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_DATA_CR;
          end
        end
        PH_DATA_CR, PH_END_CR: begin
          if (c == CHAR_CR) begin
            phase_d = (phase_q == PH_DATA_CR) ? PH_DATA_LF : PH_END_LF;
          end else begin
            phase_d        = PH_FINISHED;
            final_status_d = hbd_pkg::ST_BAD;
          end
        end
        PH_DATA_LF: begin
          if (c == CHAR_LF) begin
            phase_d = PH_LINE;
          end else begin
            phase_d        = PH_FINISHED;
            final_status_d = hbd_pkg::ST_BAD;
          end
        end
        PH_END_LF: begin
          phase_d        = PH_FINISHED;
          final_status_d = (c == CHAR_LF) ? hbd_pkg::ST_DONE : hbd_pkg::ST_BAD;
        end
        default: begin
          // idle or finished: byte is ignored
        end
      endcase
    end
  end

  // result word
  always_comb begin
    out_d.data_valid = pass;
    out_d.data_out   = pass ? c : '0;
    out_d.status     = (phase_d == PH_FINISHED) ? final_status_d : hbd_pkg::ST_RUN;
    out_d.body_bytes = accepted_d;
  end

  // size limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= hbd_pkg::MAX_BODY_RESET;
    end else if (cfg_we_i) begin
      max_body_q <= cfg_wdata_i;
    end
  end

  // framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      remaining_q    <= '0;
      size_accum_q   <= '0;
      digit_count_q  <= '0;
      accepted_q     <= '0;
      over_limit_q   <= 1'b0;
      final_status_q <= hbd_pkg::ST_RUN;
    end else if (in_accept) begin
      phase_q        <= phase_d;
      remaining_q    <= remaining_d;
      size_accum_q   <= size_accum_d;
      digit_count_q  <= digit_count_d;
      accepted_q     <= accepted_d;
      over_limit_q   <= over_limit_d;
      final_status_q <= final_status_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_i;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== bench/tb_http_body_deframer.sv =====
// self-checking bench for the http body deframer: random framed bodies, stalls, limit changes
`timescale 1ns / 1ps

module tb_http_body_deframer;

  localparam int unsigned LenW  = hbd_pkg::LenW;
  localparam int unsigned StatW = hbd_pkg::StatW;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;

  localparam logic [LenW-1:0] LIMIT_MAX = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    FR_IDLE, FR_LENGTH, FR_LINE, FR_LEAD_LF, FR_SIZE, FR_SIZE_LF,
    FR_DATA, FR_DATA_CR, FR_DATA_LF, FR_LAST_CR, FR_LAST_LF, FR_FINISHED
  } frame_phase_e;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  hbd_pkg::in_t    in_data_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  hbd_pkg::out_t   out_data_o;
  logic            cfg_we_i    = 1'b0;
  logic [LenW-1:0] cfg_wdata_i = '0;

  // words waiting to be sent and results waiting to be seen
  hbd_pkg::in_t  body_words[$];
  hbd_pkg::out_t deframed_words[$];
  int unsigned   words_queued;
  int unsigned   deframed_count;
  int unsigned   mismatch_count;
  int unsigned   idle_pct;

  // framing state of the predictor
  frame_phase_e     fr_phase;
  logic [LenW-1:0]  body_limit;
  logic [LenW-1:0]  bytes_left;
  logic [LenW-1:0]  payload_count;
  logic [31:0]      size_acc;
  int unsigned      size_digits;
  logic             over_limit;
  logic [StatW-1:0] outcome;

  // driver and receiver private counters
  int unsigned send_gap;
  int unsigned stall_burst;
  int unsigned long_stall_left;
  bit          long_stall_done;

  http_body_deframer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF_HEX) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic void close_body(input logic [StatW-1:0] st);
    outcome  = st;
    fr_phase = FR_FINISHED;
  endfunction

  function automatic void add_size_digit(input int d);
    if (size_digits >= hbd_pkg::MAX_SIZE_DIGITS) begin
      close_body(hbd_pkg::ST_BAD);
    end else begin
      size_digits++;
      // saturate instead of wrapping
      if (size_acc > 32'h0FFF_FFFF) size_acc = '1;
      else size_acc = {size_acc[27:0], 4'(d)};
    end
  endfunction

  function automatic void open_body(input hbd_pkg::in_t w);
    bytes_left    = '0;
    size_acc      = '0;
    size_digits   = 0;
    payload_count = '0;
    over_limit    = 1'b0;
    outcome       = hbd_pkg::ST_RUN;
    if (w.skip_body) begin
      close_body(hbd_pkg::ST_DONE);
    end else if (w.chunked) begin
      fr_phase = FR_LINE;
    end else if (w.length_known) begin
      over_limit = (w.content_length > body_limit);
      bytes_left = w.content_length;
      fr_phase   = FR_LENGTH;
      if (bytes_left == '0) close_body(over_limit ? hbd_pkg::ST_LARGE : hbd_pkg::ST_DONE);
    end else if (!w.bytes_follow || w.has_trailers) begin
      close_body(hbd_pkg::ST_DONE);
    end else begin
      close_body(hbd_pkg::ST_LENREQ);
    end
  endfunction

  // expected result word for one accepted input word
  function automatic hbd_pkg::out_t deframe_word(input hbd_pkg::in_t w);
    hbd_pkg::out_t r;
    int            d;
    logic          pass;
    logic [7:0]    c;
    pass = 1'b0;
    c    = w.data_in;
    if (w.kind == KIND_START) begin
      open_body(w);
    end else begin
      case (fr_phase)
        FR_LENGTH: begin
          if (!over_limit) begin
            pass = 1'b1;
            payload_count++;
          end
          bytes_left--;
          if (bytes_left == '0)
            close_body(over_limit ? hbd_pkg::ST_LARGE : hbd_pkg::ST_DONE);
        end
        FR_LINE: begin
          if (c == CH_CR) begin
            fr_phase = FR_LEAD_LF;
          end else begin
            d = hex_nibble(c);
            if (d < 0) begin
              close_body(hbd_pkg::ST_BAD);
            end else begin
              size_acc    = '0;
              size_digits = 0;
              fr_phase    = FR_SIZE;
              add_size_digit(d);
            end
          end
        end
        FR_LEAD_LF: begin
          if (c == CH_LF) fr_phase = FR_LINE;
          else close_body(hbd_pkg::ST_BAD);
        end
        FR_SIZE: begin
          if (c == CH_CR) begin
            fr_phase = FR_SIZE_LF;
          end else begin
            d = hex_nibble(c);
            if (d < 0) close_body(hbd_pkg::ST_BAD);
            else add_size_digit(d);
          end
        end
        FR_SIZE_LF: begin
          // limit is checked once the size line is complete
          if (c != CH_LF) begin
            close_body(hbd_pkg::ST_BAD);
          end else if (33'(payload_count) + 33'(size_acc) > 33'(body_limit)) begin
            close_body(hbd_pkg::ST_LARGE);
          end else if (size_acc == '0) begin
            fr_phase = FR_LAST_CR;
          end else begin
            bytes_left = size_acc[LenW-1:0];
            fr_phase   = FR_DATA;
          end
        end
        FR_DATA: begin
          pass = 1'b1;
          payload_count++;
          bytes_left--;
          if (bytes_left == '0) fr_phase = FR_DATA_CR;
        end
        FR_DATA_CR: begin
          if (c == CH_CR) fr_phase = FR_DATA_LF;
          else close_body(hbd_pkg::ST_BAD);
        end
        FR_DATA_LF: begin
          if (c == CH_LF) fr_phase = FR_LINE;
          else close_body(hbd_pkg::ST_BAD);
        end
        FR_LAST_CR: begin
          if (c == CH_CR) fr_phase = FR_LAST_LF;
          else close_body(hbd_pkg::ST_BAD);
        end
        FR_LAST_LF: close_body((c == CH_LF) ? hbd_pkg::ST_DONE : hbd_pkg::ST_BAD);
        default: ;
      endcase
    end
    r.data_valid = pass;
    r.data_out   = pass ? c : '0;
    r.status     = (fr_phase == FR_FINISHED) ? outcome : hbd_pkg::ST_RUN;
    r.body_bytes = payload_count;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic hbd_pkg::in_t random_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(hbd_pkg::in_t)-1:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_0 + 8'(n);
    return (($urandom_range(0, 1) == 1) ? CH_UA : CH_LA) + 8'(n) - 8'd10;
  endfunction

  // bytes that steer the parser more often than plain random ones
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return hex_char(4'($urandom));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] c);
    hbd_pkg::in_t w;
    w         = random_word();
    w.kind    = KIND_BYTE;
    w.data_in = c;
    body_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_crlf();
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic push_start(input logic chunked, input logic known,
                            input logic [LenW-1:0] clen, input logic follow,
                            input logic trailers, input logic skip);
    hbd_pkg::in_t w;
    w                = random_word();
    w.kind           = KIND_START;
    w.chunked        = chunked;
    w.length_known   = known;
    w.content_length = clen;
    w.bytes_follow   = follow;
    w.has_trailers   = trailers;
    w.skip_body      = skip;
    body_words.push_back(w);
    words_queued++;
  endtask

  // chunked body, well formed unless broken on purpose
  task automatic gen_chunked(input bit corrupt);
    logic [7:0]  seq[$];
    logic [31:0] size_val;
    int          n_chunks;
    int          ndig;
    int          pos;
    bit          big;
    big = 1'b0;
    push_start(1'b1, 1'($urandom_range(0, 1)), 31'($urandom), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'b0);
    repeat ($urandom_range(0, 2)) begin
      seq.push_back(CH_CR);
      seq.push_back(CH_LF);
    end
    n_chunks = $urandom_range(0, 3);
    for (int k = 0; k < n_chunks && !big; k++) begin
      big      = ($urandom_range(0, 19) == 0);
      size_val = big ? ($urandom | 32'h8000_0000) : 32'($urandom_range(1, 12));
      ndig = 1;
      while (ndig < 8 && (size_val >> (4 * ndig)) != 0) ndig++;
      // leading zeros, sometimes past the digit limit
      if ($urandom_range(0, 7) == 0) ndig += $urandom_range(1, 8);
      for (int i = ndig - 1; i >= 0; i--) begin
        seq.push_back(hex_char((i < 8) ? size_val[4 * i +: 4] : 4'd0));
      end
      seq.push_back(CH_CR);
      seq.push_back(CH_LF);
      if (!big) begin
        repeat (size_val) seq.push_back(8'($urandom));
        seq.push_back(CH_CR);
        seq.push_back(CH_LF);
      end
    end
    if (!big) begin
      repeat ($urandom_range(1, 2)) seq.push_back(CH_0);
      repeat (2) begin
        seq.push_back(CH_CR);
        seq.push_back(CH_LF);
      end
    end
    if (corrupt) begin
      pos = $urandom_range(0, seq.size() - 1);
      case ($urandom_range(0, 2))
        0:       seq[pos] = noise_byte();
        1:       seq.delete(pos);
        default: while (seq.size() > pos) void'(seq.pop_back());
      endcase
    end
    foreach (seq[i]) push_byte(seq[i]);
    repeat ($urandom_range(0, 2)) push_byte(noise_byte());
  endtask

  // content length body, sometimes cut short by the next start
  task automatic gen_length();
    logic [LenW-1:0] clen;
    int              n;
    case ($urandom_range(0, 3))
      0, 1: clen = 31'($urandom_range(0, 16));
      2: begin
        if (body_limit <= 40)
          clen = (body_limit == '0) ? 31'($urandom_range(0, 2))
                                    : body_limit - 31'd1 + 31'($urandom_range(0, 2));
        else
          clen = 31'($urandom_range(0, 16));
      end
      default: clen = 31'($urandom);
    endcase
    push_start(1'b0, 1'b1, clen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    if (clen > 64) n = $urandom_range(1, 6);
    else if ($urandom_range(0, 4) == 0) n = $urandom_range(0, int'(clen));
    else n = int'(clen) + $urandom_range(0, 2);
    repeat (n) push_byte(8'($urandom));
  endtask

  task automatic run_mix(input int unsigned n);
    int unsigned stop_at;
    stop_at = words_queued + n;
    while (words_queued < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: gen_chunked(1'b0);
        8, 9, 10:               gen_chunked(1'b1);
        11, 12, 13, 14:         gen_length();
        15, 16: begin
          push_start(1'b0, 1'b0, 31'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'b0);
          repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
        end
        17: begin
          push_start(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 31'($urandom),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
          repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
        end
        default: repeat ($urandom_range(1, 5)) push_byte(noise_byte());
      endcase
    end
  endtask

  // sender pause: nothing goes out until every result is back
  task automatic wait_drained();
    while (body_words.size() != 0 || in_valid_i || deframed_words.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LenW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    body_limit = v;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) deframed_words.push_back(deframe_word(in_data_i));
      if (in_valid_i && in_stall_o) begin
        // word held until taken
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (body_words.size() != 0) begin
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i  <= body_words.pop_front();
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (long_stall_left != 0) begin
      long_stall_left--;
      out_stall_i <= 1'b1;
    end else if (!long_stall_done && deframed_count >= 250) begin
      // long hold-off so the input side backs up
      long_stall_done = 1'b1;
      long_stall_left = 79;
      out_stall_i <= 1'b1;
    end else if (stall_burst != 0) begin
      stall_burst--;
      out_stall_i <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_burst = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    hbd_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      deframed_count++;
      if (deframed_words.size() == 0) begin
        flag_mismatch("unexpected word", 32'(out_data_o), '0);
      end else begin
        want = deframed_words.pop_front();
        if (out_data_o.data_valid !== want.data_valid)
          flag_mismatch("data_valid", 32'(out_data_o.data_valid), 32'(want.data_valid));
        if (out_data_o.data_out !== want.data_out)
          flag_mismatch("data_out", 32'(out_data_o.data_out), 32'(want.data_out));
        if (out_data_o.status !== want.status)
          flag_mismatch("status", 32'(out_data_o.status), 32'(want.status));
        if (out_data_o.body_bytes !== want.body_bytes)
          flag_mismatch("body_bytes", 32'(out_data_o.body_bytes), 32'(want.body_bytes));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    fr_phase      = FR_IDLE;
    body_limit    = hbd_pkg::MAX_BODY_RESET;
    bytes_left    = '0;
    payload_count = '0;
    size_acc      = '0;
    size_digits   = 0;
    over_limit    = 1'b0;
    outcome       = hbd_pkg::ST_RUN;
    idle_pct      = 20;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: ignored bytes, every start framing, length and chunk basics
    push_byte(8'hFF);
    push_start(1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
    push_byte(8'h00);
    push_start(1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
    push_start(1'b0, 1'b0, '0, 1'b1, 1'b0, 1'b0);
    push_start(1'b0, 1'b0, '0, 1'b1, 1'b1, 1'b0);
    push_start(1'b0, 1'b1, '0, 1'b0, 1'b0, 1'b0);
    push_start(1'b0, 1'b1, 31'd2, 1'b0, 1'b0, 1'b0);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_start(1'b0, 1'b1, LIMIT_MAX, 1'b0, 1'b0, 1'b0);
    push_byte(8'h5A);
    push_start(1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0);
    push_crlf();
    push_byte("1");
    push_crlf();
    push_byte("A");
    push_crlf();
    push_byte("0");
    push_crlf();
    push_crlf();

    // random bodies under several limits
    run_mix(420);
    wait_drained();
    write_limit('0);
    run_mix(200);
    wait_drained();
    idle_pct = 0;
    write_limit(LIMIT_MAX);
    run_mix(250);
    wait_drained();
    idle_pct = 30;
    write_limit(31'd24);
    run_mix(400);
    wait_drained();
    idle_pct = 15;
    write_limit(31'($urandom_range(0, 64)));
    run_mix(250);
    wait_drained();
    // closing stretch at full rate
    idle_pct = 0;
    write_limit(31'($urandom_range(8, 48)));
    run_mix(200);
    wait_drained();

    if (deframed_words.size() != 0)
      flag_mismatch("missing words", 32'(deframed_words.size()), '0);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
